[rtl/core/csia_pkg.sv]
// types and constants shared by the checked signed alu
`timescale 1ns / 1ps
package csia_pkg;
   typedef enum logic [2:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_DIV = 3'd3,
      OP_REM = 3'd4
   } op_type;

   // control carried alongside the data through the cell row
   typedef struct packed {
      logic        valid;
      logic [2:0]  op;
      logic        err;
      logic        neg_q;
      logic        neg_r;
      logic [31:0] early;
   } ctl_type;
endpackage

[rtl/core/checked_signed_int_alu.sv]
// top level of the overflow-checked signed 32-bit alu
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+-----------------------------------
//  request | req_valid | req_stall | req_type, operand_a, operand_b
//  result  | rsp_valid | rsp_stall | result_value, status
//
// one item enters per cycle while the row is not frozen by a stalled result;
// the result passes 34 register stages (front stage, 32 divide cells, output
// register), the cell count set by the one-bit-per-cell divide row
// add, sub and mul results ride the same row so order is kept
// synchronous active-high reset clears all valid bits
// the whole row freezes while a valid result is stalled at the output
`timescale 1ns / 1ps
module checked_signed_int_alu import csia_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_type,
   input  logic signed [31:0] operand_a,
   input  logic signed [31:0] operand_b,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] result_value,
   output logic               status
);
   localparam int Cells = 32;

   ctl_type     ctl_w [Cells+1];
   logic [31:0] rem_w [Cells+1];
   logic [31:0] quo_w [Cells+1];
   logic [31:0] div_w [Cells+1];
   logic        advance;
   logic        valid_ff;
   logic [31:0] value_ff, value_in;
   logic        status_ff;
   ctl_type     last;

   // row moves whenever the output slot is empty or being taken
   assign advance   = !(valid_ff && rsp_stall);
   assign req_stall = !advance;

   csia_front u_front (
      .clock, .reset, .advance,
      .in_valid (req_valid),
      .req_type, .operand_a, .operand_b,
      .ctl_out  (ctl_w[0]),
      .quo_out  (quo_w[0]),
      .div_out  (div_w[0])
   );
   assign rem_w[0] = '0;

   for (genvar i = 0; i < Cells; i++) begin : g_cell
      csia_cell u_cell (
         .clock, .reset, .advance,
         .ctl_in  (ctl_w[i]),
         .rem_in  (rem_w[i]),
         .quo_in  (quo_w[i]),
         .div_in  (div_w[i]),
         .ctl_out (ctl_w[i+1]),
         .rem_out (rem_w[i+1]),
         .quo_out (quo_w[i+1]),
         .div_out (div_w[i+1])
      );
   end

   assign last = ctl_w[Cells];

   // sign fixup of quotient and remainder, add, sub and mul take the early result, error forces zero
   always_comb begin
      case (last.op)
         OP_DIV:  value_in = last.neg_q ? 32'(-quo_w[Cells]) : quo_w[Cells];
         OP_REM:  value_in = last.neg_r ? 32'(-rem_w[Cells]) : rem_w[Cells];
         default: value_in = last.early;
      endcase
      if (last.err) begin
         value_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= last.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         value_ff  <= value_in;
         status_ff <= last.err;
      end
   end

   assign rsp_valid    = valid_ff;
   assign result_value = value_ff;
   assign status       = status_ff;

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status |-> result_value == '0)
      else $error("error item with nonzero value");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(result_value))
      else $error("stalled result changed");
   a_stall_link: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without output backpressure");
endmodule

[rtl/core/csia_cell.sv]
// one restoring divide step cell with its control pipeline register
`timescale 1ns / 1ps
module csia_cell import csia_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  ctl_type     ctl_in,
   input  logic [31:0] rem_in,
   input  logic [31:0] quo_in,
   input  logic [31:0] div_in,
   output ctl_type     ctl_out,
   output logic [31:0] rem_out,
   output logic [31:0] quo_out,
   output logic [31:0] div_out
);
   logic [32:0] shifted;
   logic [32:0] diff;
   logic        ge;
   logic        valid_ff;
   ctl_type     ctl_ff;
   logic [31:0] rem_ff, quo_ff, div_ff;

   assign shifted = {rem_in, quo_in[31]};
   assign diff    = shifted - {1'b0, div_in};
   assign ge      = !diff[32];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= ctl_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ctl_ff <= ctl_in;
         rem_ff <= ge ? diff[31:0] : shifted[31:0];
         quo_ff <= {quo_in[30:0], ge};
         div_ff <= div_in;
      end
   end

   always_comb begin
      ctl_out       = ctl_ff;
      ctl_out.valid = valid_ff;
   end
   assign rem_out = rem_ff;
   assign quo_out = quo_ff;
   assign div_out = div_ff;
endmodule

[rtl/core/csia_front.sv]
// input register stage: add, subtract, multiply and divide setup
`timescale 1ns / 1ps
module csia_front import csia_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  logic        in_valid,
   input  logic [2:0]  req_type,
   input  logic signed [31:0] operand_a,
   input  logic signed [31:0] operand_b,
   output ctl_type     ctl_out,
   output logic [31:0] quo_out,
   output logic [31:0] div_out
);
   logic signed [32:0] sum33, dif33;
   logic signed [63:0] prod;
   logic [31:0] mag_a, mag_b;
   logic        is_div;
   ctl_type     ctl_in, ctl_ff;
   logic        valid_ff;
   logic [31:0] quo_ff, div_ff;

   assign sum33 = {operand_a[31], operand_a} + {operand_b[31], operand_b};
   assign dif33 = {operand_a[31], operand_a} - {operand_b[31], operand_b};
   assign prod  = operand_a * operand_b;
   assign mag_a = operand_a[31] ? 32'(-operand_a) : operand_a;
   assign mag_b = operand_b[31] ? 32'(-operand_b) : operand_b;
   assign is_div = (req_type == OP_DIV) || (req_type == OP_REM);

   always_comb begin
      ctl_in       = '0;
      ctl_in.valid = in_valid;
      ctl_in.op    = req_type;
      ctl_in.neg_q = operand_a[31] ^ operand_b[31];
      ctl_in.neg_r = operand_a[31];
      case (req_type)
         OP_ADD: begin
            ctl_in.err   = sum33[32] != sum33[31];
            ctl_in.early = sum33[31:0];
         end
         OP_SUB: begin
            ctl_in.err   = dif33[32] != dif33[31];
            ctl_in.early = dif33[31:0];
         end
         OP_MUL: begin
            ctl_in.err   = prod[63:31] != {33{prod[31]}};
            ctl_in.early = prod[31:0];
         end
         OP_DIV, OP_REM: begin
            ctl_in.err = (operand_b == '0) ||
                         (operand_a == 32'sh8000_0000 && operand_b == -32'sd1);
         end
         default: ctl_in.err = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ctl_ff <= ctl_in;
         quo_ff <= is_div ? mag_a : '0;
         div_ff <= is_div ? mag_b : 32'd1;
      end
   end

   always_comb begin
      ctl_out       = ctl_ff;
      ctl_out.valid = valid_ff;
   end
   assign quo_out = quo_ff;
   assign div_out = div_ff;
endmodule
